### rtl/gbs_pkg.sv
// shared types, constants and register codes for the ground barrier stiffness block
package gbs_pkg;

    localparam int unsigned MAX_VERTICES = 65536;

    localparam int DIST_W  = 31;
    localparam int GAIN_W  = 32;
    localparam int VIDX_W  = 16;
    localparam int H_W     = 32;
    localparam int EIDX_W  = 18;
    localparam int VAL_W   = 48;
    localparam int CFG_W   = 32;
    localparam int RQ_W    = 63;
    localparam int DIV_STEPS = 63;
    localparam int LOG_FRAC  = 16;
    localparam int LN_W      = 21;

    localparam logic [DIST_W-1:0] DIST_RESET = 31'd1048576;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd65536;
    localparam logic [31:0]       LN2_Q32    = 32'd2977044472;
    localparam logic [63:0]       F_CAP      = 64'h8000_0000_0000_0000;
    localparam logic [79:0]       MAG_CAP    = 80'h8000_0000_0000;
    localparam logic [64:0]       THREE_Q16  = 65'd196608;

    typedef enum logic {
        CFG_DISTANCE = 1'b0,
        CFG_GAIN     = 1'b1
    } t_cfg_idx;

    // control that travels with every item
    typedef struct packed {
        logic                vld;
        logic                ok;
        logic [EIDX_W-1:0]   idx;
    } t_ctl;

endpackage

### rtl/gbs_div.sv
// pipelined restoring divider, one quotient bit per stage: q = (d << 32) / h
module gbs_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gbs_pkg::t_ctl               i_ctl,
    input  logic [gbs_pkg::DIST_W-1:0]  i_d,
    input  logic [gbs_pkg::DIST_W-1:0]  i_h,
    output gbs_pkg::t_ctl               o_ctl,
    output logic [gbs_pkg::RQ_W-1:0]    o_q
);
    localparam int N = gbs_pkg::DIV_STEPS;
    localparam int W = gbs_pkg::DIST_W;

    gbs_pkg::t_ctl      r_ctl [1:N];
    logic [W-1:0]       r_d   [1:N];
    logic [W-1:0]       r_h   [1:N];
    logic [W-1:0]       r_rem [1:N];
    logic [gbs_pkg::RQ_W-1:0] r_q [1:N];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            gbs_pkg::t_ctl          c_ctl;
            logic [W-1:0]           c_d;
            logic [W-1:0]           c_h;
            logic [W-1:0]           c_rem;
            logic [gbs_pkg::RQ_W-1:0] c_q;
            logic                   c_bit;
            logic [W:0]             c_t;
            logic                   c_ge;
            logic [W-1:0]           n_rem;

            if (k == 0) begin : g_first
                assign c_ctl = i_ctl;
                assign c_d   = i_d;
                assign c_h   = i_h;
                assign c_rem = '0;
                assign c_q   = '0;
            end else begin : g_next
                assign c_ctl = r_ctl[k];
                assign c_d   = r_d[k];
                assign c_h   = r_h[k];
                assign c_rem = r_rem[k];
                assign c_q   = r_q[k];
            end

            // dividend bits: distance first, then zeros
            if (k < W) begin : g_dbit
                assign c_bit = c_d[W-1-k];
            end else begin : g_zbit
                assign c_bit = 1'b0;
            end

            assign c_t   = {c_rem, c_bit};
            assign c_ge  = (c_t >= {1'b0, c_h});
            assign n_rem = c_ge ? W'(c_t - {1'b0, c_h}) : c_t[W-1:0];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_ctl[k+1].vld <= 1'b0;
                end else begin
                    r_ctl[k+1].vld <= c_ctl.vld;
                end
                r_ctl[k+1].ok  <= c_ctl.ok;
                r_ctl[k+1].idx <= c_ctl.idx;
                r_d[k+1]       <= c_d;
                r_h[k+1]       <= c_h;
                r_rem[k+1]     <= n_rem;
                r_q[k+1]       <= {c_q[gbs_pkg::RQ_W-2:0], c_ge};
            end
        end
    endgenerate

    assign o_ctl = r_ctl[N];
    assign o_q   = r_q[N];

endmodule

### rtl/gbs_log.sv
// pipelined ln(r) in q16 from r in q32: leading-one normalise, 16 squaring steps, scale by ln 2
module gbs_log #(
    parameter int SW = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic [SW-1:0]               i_side,
    input  logic [55:0]                 i_rq,
    output logic                        o_vld,
    output logic [SW-1:0]               o_side,
    output logic [gbs_pkg::LN_W-1:0]    o_ln
);
    localparam int NF = gbs_pkg::LOG_FRAC;

    // normalise stage
    logic [4:0]  c_ip;
    logic [4:0]  c_sh;
    logic [55:0] c_shifted;

    always_comb begin
        c_ip = 5'd0;
        for (int b = 0; b < 24; b++) begin
            if (i_rq[32+b]) begin
                c_ip = 5'(b);
            end
        end
        c_sh      = 5'(c_ip + 5'd1);
        c_shifted = i_rq >> c_sh;
    end

    logic              r_vld  [0:NF];
    logic [SW-1:0]     r_side [0:NF];
    logic [31:0]       r_m    [0:NF];
    logic [4:0]        r_ip   [0:NF];
    logic [NF-1:0]     r_frac [0:NF];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
        r_side[0] <= i_side;
        r_m[0]    <= c_shifted[31:0];
        r_ip[0]   <= c_ip;
        r_frac[0] <= '0;
    end

    genvar k;
    generate
        for (k = 0; k < NF; k++) begin : g_sq
            logic [63:0] c_sq;
            assign c_sq = r_m[k] * r_m[k];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k+1] <= 1'b0;
                end else begin
                    r_vld[k+1] <= r_vld[k];
                end
                r_side[k+1] <= r_side[k];
                r_ip[k+1]   <= r_ip[k];
                // mantissa squared reaches two: halve and emit a one
                r_m[k+1]    <= c_sq[63] ? c_sq[63:32] : c_sq[62:31];
                r_frac[k+1] <= {r_frac[k][NF-2:0], c_sq[63]};
            end
        end
    endgenerate

    // scale log2 by ln 2
    logic [gbs_pkg::LN_W-1:0] c_l2;
    logic                     r_ovld;
    logic [SW-1:0]            r_oside;
    logic [52:0]              r_prod;

    assign c_l2 = {r_ip[NF], r_frac[NF]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= r_vld[NF];
        end
        r_oside <= r_side[NF];
        r_prod  <= c_l2 * gbs_pkg::LN2_Q32;
    end

    assign o_vld  = r_ovld;
    assign o_side = r_oside;
    assign o_ln   = r_prod[52:32];

endmodule

### rtl/ground_barrier_stiffness.sv
// top level of the ground barrier stiffness block: entry, divide, square, log, gain, output
//
// takes one item per clock: an item is taken whenever start is high, busy stays low, and
// each item leaves as a one-cycle o_strobe pulse carrying the diagonal entry index and the
// negated stiffness; the receiver cannot stall, so the pipeline never holds. items pass
// the entry stage, the 63-stage bit-per-cycle divider that forms r = distance / height,
// the square stages, the 18-stage logarithm (normalise, 16 squaring steps, ln 2 scale) and
// the f, gain and output stages. configuration registers are read live by the entry and
// gain stages, so they should only be written while no item is in flight
module ground_barrier_stiffness (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [gbs_pkg::VIDX_W-1:0]          i_vertex_index,
    input  logic signed [gbs_pkg::H_W-1:0]      i_height,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_idx,
    input  logic [gbs_pkg::CFG_W-1:0]           i_cfg_wdata,
    output logic                                o_strobe,
    output logic [gbs_pkg::EIDX_W-1:0]          o_entry_index,
    output logic signed [gbs_pkg::VAL_W-1:0]    o_entry_value
);
    // fully pipelined, never refuses an item
    assign busy = 1'b0;

    // configuration registers
    logic [gbs_pkg::DIST_W-1:0] r_dist;
    logic [gbs_pkg::GAIN_W-1:0] r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist <= gbs_pkg::DIST_RESET;
            r_gain <= gbs_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (gbs_pkg::t_cfg_idx'(i_cfg_idx))
                gbs_pkg::CFG_DISTANCE: r_dist <= i_cfg_wdata[gbs_pkg::DIST_W-1:0];
                gbs_pkg::CFG_GAIN:     r_gain <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // entry stage: qualify the height and form the entry index
    logic          c_in_range;
    gbs_pkg::t_ctl r_e_ctl;
    logic [gbs_pkg::DIST_W-1:0] r_e_d;
    logic [gbs_pkg::DIST_W-1:0] r_e_h;

    assign c_in_range = (i_height != '0) && !i_height[gbs_pkg::H_W-1]
                     && (i_height[gbs_pkg::DIST_W-1:0] < r_dist)
                     && ({5'd0, i_vertex_index} < 21'(gbs_pkg::MAX_VERTICES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_ctl.vld <= 1'b0;
        end else begin
            r_e_ctl.vld <= start && !busy;
        end
        r_e_ctl.ok  <= c_in_range;
        r_e_ctl.idx <= gbs_pkg::EIDX_W'(({2'd0, i_vertex_index} * 18'd3) + 18'd2);
        r_e_d       <= r_dist;
        r_e_h       <= i_height[gbs_pkg::DIST_W-1:0];
    end

    // r in q32
    gbs_pkg::t_ctl             w_dv_ctl;
    logic [gbs_pkg::RQ_W-1:0]  w_rq;

    gbs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_e_ctl),
        .i_d     (r_e_d),
        .i_h     (r_e_h),
        .o_ctl   (w_dv_ctl),
        .o_q     (w_rq)
    );

    // square, first half: partial products of the low 56 bits of r
    gbs_pkg::t_ctl r_s1_ctl;
    logic          r_s1_big;
    logic [55:0]   r_s1_rq;
    logic [55:0]   r_s1_p11;
    logic [55:0]   r_s1_pm;
    logic [55:0]   r_s1_p00;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl.vld <= 1'b0;
        end else begin
            r_s1_ctl.vld <= w_dv_ctl.vld;
        end
        r_s1_ctl.ok  <= w_dv_ctl.ok;
        r_s1_ctl.idx <= w_dv_ctl.idx;
        r_s1_big     <= |w_rq[62:56];
        r_s1_rq      <= w_rq[55:0];
        r_s1_p11     <= w_rq[55:28] * w_rq[55:28];
        r_s1_pm      <= w_rq[55:28] * w_rq[27:0];
        r_s1_p00     <= w_rq[27:0] * w_rq[27:0];
    end

    // square, second half: r^2 in q16, capped
    logic [111:0] c_sq;
    assign c_sq = {r_s1_p11, 56'd0} + {27'd0, r_s1_pm, 29'd0} + {56'd0, r_s1_p00};

    gbs_pkg::t_ctl r_s2_ctl;
    logic          r_s2_cap;
    logic [63:0]   r_s2_r2;
    logic [55:0]   r_s2_rq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl.vld <= 1'b0;
        end else begin
            r_s2_ctl.vld <= r_s1_ctl.vld;
        end
        r_s2_ctl.ok  <= r_s1_ctl.ok;
        r_s2_ctl.idx <= r_s1_ctl.idx;
        r_s2_cap     <= r_s1_big || c_sq[111];
        r_s2_r2      <= c_sq[111:48];
        r_s2_rq      <= r_s1_rq;
    end

    // logarithm, with the square and 2r riding alongside
    localparam int SIDE_W = $bits(gbs_pkg::t_ctl) + 1 + 64 + 41;

    logic [SIDE_W-1:0]         w_side_in;
    logic [SIDE_W-1:0]         w_side_out;
    logic                      w_lg_vld;
    logic [gbs_pkg::LN_W-1:0]  w_ln;
    gbs_pkg::t_ctl             w_lg_ctl;
    logic                      w_lg_cap;
    logic [63:0]               w_lg_r2;
    logic [40:0]               w_lg_tr;

    assign w_side_in = {r_s2_ctl, r_s2_cap, r_s2_r2, r_s2_rq[55:15]};

    gbs_log #(
        .SW (SIDE_W)
    ) u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s2_ctl.vld),
        .i_side  (w_side_in),
        .i_rq    (r_s2_rq),
        .o_vld   (w_lg_vld),
        .o_side  (w_side_out),
        .o_ln    (w_ln)
    );

    assign {w_lg_ctl, w_lg_cap, w_lg_r2, w_lg_tr} = w_side_out;

    // f = r^2 + 2r + 2 ln r - 3, capped
    logic [64:0] c_fsum;
    logic [63:0] c_f;

    always_comb begin
        c_fsum = {1'b0, w_lg_r2} + {24'd0, w_lg_tr} + {43'd0, w_ln, 1'b0}
               - gbs_pkg::THREE_Q16;
        if (w_lg_cap || (c_fsum > {1'b0, gbs_pkg::F_CAP})) begin
            c_f = gbs_pkg::F_CAP;
        end else begin
            c_f = c_fsum[63:0];
        end
    end

    gbs_pkg::t_ctl r_s3_ctl;
    logic [63:0]   r_s3_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_ctl.vld <= 1'b0;
        end else begin
            r_s3_ctl.vld <= w_lg_vld;
        end
        r_s3_ctl.ok  <= w_lg_ctl.ok;
        r_s3_ctl.idx <= w_lg_ctl.idx;
        r_s3_f       <= c_f;
    end

    // gain times f, split in two 32x32 products
    gbs_pkg::t_ctl r_s4_ctl;
    logic [63:0]   r_s4_ghi;
    logic [63:0]   r_s4_glo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_ctl.vld <= 1'b0;
        end else begin
            r_s4_ctl.vld <= r_s3_ctl.vld;
        end
        r_s4_ctl.ok  <= r_s3_ctl.ok;
        r_s4_ctl.idx <= r_s3_ctl.idx;
        r_s4_ghi     <= r_gain * r_s3_f[63:32];
        r_s4_glo     <= r_gain * r_s3_f[31:0];
    end

    // combine, drop 16 fraction bits, saturate and negate
    logic [95:0] c_prod;
    logic [79:0] c_mag;
    logic [47:0] c_lim;
    logic [47:0] c_val;

    always_comb begin
        c_prod = {r_s4_ghi, 32'd0} + {32'd0, r_s4_glo};
        c_mag  = c_prod[95:16];
        c_lim  = (c_mag > gbs_pkg::MAG_CAP) ? gbs_pkg::MAG_CAP[47:0] : c_mag[47:0];
        c_val  = r_s4_ctl.ok ? 48'(48'd0 - c_lim) : 48'd0;
    end

    logic                        r_o_vld;
    logic [gbs_pkg::EIDX_W-1:0]  r_o_idx;
    logic [gbs_pkg::VAL_W-1:0]   r_o_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_s4_ctl.vld;
        end
        r_o_idx <= r_s4_ctl.idx;
        r_o_val <= c_val;
    end

    assign o_strobe      = r_o_vld;
    assign o_entry_index = r_o_idx;
    assign o_entry_value = signed'(r_o_val);

endmodule

### tb/ground_barrier_stiffness_test.sv
// self-checking testbench for the ground barrier stiffness block
`timescale 1ns / 1ps

// holds expected diagonal entries in order and checks each strobed result against them
class entry_scoreboard;
    bit [17:0] idx_q[$];
    bit [47:0] val_q[$];
    int        errors;

    bit [30:0] distance;
    bit [31:0] gain;

    function new();
        errors   = 0;
        distance = gbs_pkg::DIST_RESET;
        gain     = gbs_pkg::GAIN_RESET;
    endfunction

    // ln(r) in q16 from r in q32, by leading bit and repeated squaring
    function bit [63:0] ln_of_ratio(bit [63:0] rq);
        int        pos;
        bit [63:0] m;
        bit [63:0] l2;
        bit [95:0] prod;
        pos = 63;
        while (pos > 32 && rq[pos] == 1'b0) pos--;
        m  = rq >> (pos - 31);
        l2 = 64'(pos - 32) << 16;
        for (int i = 15; i >= 0; i--) begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                l2[i] = 1'b1;
            end
        end
        prod = 96'(l2) * 96'(gbs_pkg::LN2_Q32);
        return prod[95:32];
    endfunction

    function bit [63:0] stiffness_shape(bit [63:0] rq);
        bit [127:0] sq;
        bit [63:0]  r2;
        bit [64:0]  sum;
        if (rq >= 64'd1 << 56) return gbs_pkg::F_CAP;
        sq = 128'(rq) * 128'(rq);
        if (sq[127:64] >= 64'd1 << 47) return gbs_pkg::F_CAP;
        r2 = sq[111:48];
        if (r2 >= gbs_pkg::F_CAP) return gbs_pkg::F_CAP;
        sum = 65'(r2) + 65'(rq >> 15) + 65'(2 * ln_of_ratio(rq)) - 65'(3 << 16);
        return (sum > 65'(gbs_pkg::F_CAP)) ? gbs_pkg::F_CAP : sum[63:0];
    endfunction

    function void write_reg(gbs_pkg::t_cfg_idx which, bit [31:0] data);
        if (which == gbs_pkg::CFG_DISTANCE) distance = data[30:0];
        else gain = data;
    endfunction

    // work out the expected entry for one accepted vertex
    function void note_vertex(bit [15:0] vidx, bit [31:0] h);
        bit [63:0]  rq;
        bit [63:0]  f;
        bit [127:0] gp;
        bit [63:0]  mag;
        bit [47:0]  value;
        value = '0;
        if (h != 0 && h[31] == 1'b0 && h < 32'(distance)) begin
            rq  = (64'(distance) << 32) / 64'(h);
            f   = stiffness_shape(rq);
            gp  = 128'(gain) * 128'(f);
            if (gp[127:64] >= 64'd1 << 16) mag = 64'h8000_0000_0000;
            else mag = gp[79:16];
            if (mag > 64'h8000_0000_0000) mag = 64'h8000_0000_0000;
            value = 48'(64'd0 - mag);
        end
        idx_q.push_back(18'(3 * 32'(vidx) + 2));
        val_q.push_back(value);
    endfunction

    task report(string what, bit [63:0] got, bit [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    task check_entry(bit [17:0] idx, bit [47:0] value);
        bit [17:0] ei;
        bit [47:0] ev;
        if (idx_q.size() == 0) begin
            report("unexpected entry", 64'(idx), 0);
            return;
        end
        ei = idx_q.pop_front();
        ev = val_q.pop_front();
        if (idx !== ei) report("entry_index", 64'(idx), 64'(ei));
        if (value !== ev) report("entry_value", 64'(value), 64'(ev));
    endtask
endclass

module ground_barrier_stiffness_test;

    localparam int LATENCY   = 87;
    localparam int N_RANDOM  = 1950;
    localparam int CYCLE_CAP = 200000;

    logic                                    clk;
    logic                                    rst_n;
    logic                                    start;
    logic                                    busy;
    logic [gbs_pkg::VIDX_W-1:0]              vertex_index;
    logic signed [gbs_pkg::H_W-1:0]          height;
    logic                                    cfg_we;
    logic                                    cfg_idx;
    logic [gbs_pkg::CFG_W-1:0]               cfg_wdata;
    logic                                    strobe;
    logic [gbs_pkg::EIDX_W-1:0]              entry_index;
    logic signed [gbs_pkg::VAL_W-1:0]        entry_value;

    entry_scoreboard sb;
    int              sender_idle;   // percentage of cycles with start held low
    int              cycles;

    ground_barrier_stiffness dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .start          (start),
        .busy           (busy),
        .i_vertex_index (vertex_index),
        .i_height       (height),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (cfg_wdata),
        .o_strobe       (strobe),
        .o_entry_index  (entry_index),
        .o_entry_value  (entry_value)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: a stuck handshake must not hang the run
    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_CAP) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // results cannot be held off, so every strobe is checked at the edge that ends it
    always @(posedge clk) begin
        if (rst_n && strobe === 1'b1) sb.check_entry(entry_index, entry_value);
    end

    // one register write while nothing is in flight
    task automatic write_cfg(gbs_pkg::t_cfg_idx which, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= which;
        cfg_wdata <= data;
        @(posedge clk);
        sb.write_reg(which, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // offer one item; start stays high across back-to-back items
    task automatic send_vertex(logic [15:0] vidx, logic [31:0] h);
        while ($urandom_range(99) < sender_idle) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start        <= 1'b1;
        vertex_index <= vidx;
        height       <= h;
        @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
        sb.note_vertex(vidx, h);
        @(negedge clk);
    endtask

    // let the pipeline empty before touching registers
    task automatic drain();
        start <= 1'b0;
        while (sb.idx_q.size() != 0) @(negedge clk);
        repeat (LATENCY + 8) @(negedge clk);
    endtask

    // heights mostly inside the barrier band so the log path gets exercised
    function automatic logic [31:0] pick_height(logic [30:0] d);
        int sel;
        sel = $urandom_range(99);
        if (sel < 70 && d > 1) return 32'($urandom_range(32'(d) - 1, 1));
        if (sel < 75) return 32'($urandom_range(3, 1));
        if (sel < 80) return 32'(d) - 32'($urandom_range(2, 0));
        return $urandom();
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) send_vertex(16'($urandom()), pick_height(sb.distance));
    endtask

    initial begin
        sb           = new();
        rst_n        = 1'b0;
        start        = 1'b0;
        vertex_index = '0;
        height       = '0;
        cfg_we       = 1'b0;
        cfg_idx      = gbs_pkg::CFG_DISTANCE;
        cfg_wdata    = '0;
        sender_idle  = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset settings, ground contact, band edges, index extremes
        send_vertex(16'd0, 32'd0);
        send_vertex(16'hFFFF, 32'h8000_0000);
        send_vertex(16'd1, 32'hFFFF_FFFF);
        send_vertex(16'd2, 32'd1);
        send_vertex(16'd3, 32'd524288);
        send_vertex(16'd4, 32'd1048575);
        send_vertex(16'd5, 32'd1048576);
        send_vertex(16'd6, 32'h7FFF_FFFF);
        send_vertex(16'hAAAA, 32'h5555_5555);
        drain();

        // widest band and largest gain: saturation
        write_cfg(gbs_pkg::CFG_DISTANCE, 32'h7FFF_FFFF);
        write_cfg(gbs_pkg::CFG_GAIN, 32'hFFFF_FFFF);
        send_vertex(16'd7, 32'd1);
        send_vertex(16'd8, 32'h7FFF_FFFE);
        send_vertex(16'h5555, 32'h4000_0000);
        send_vertex(16'd9, 32'd1000);
        drain();

        // zero gain, then the smallest distance
        write_cfg(gbs_pkg::CFG_GAIN, 32'd0);
        send_vertex(16'd10, 32'd12345);
        drain();
        write_cfg(gbs_pkg::CFG_DISTANCE, 32'd1);
        write_cfg(gbs_pkg::CFG_GAIN, 32'd65536);
        send_vertex(16'd11, 32'd1);
        send_vertex(16'd12, 32'd0);
        drain();

        // random phases, each with its own register setting, and with varied idling
        write_cfg(gbs_pkg::CFG_DISTANCE, 32'd1048576);
        write_cfg(gbs_pkg::CFG_GAIN, $urandom());
        sender_idle = 36;
        random_phase(N_RANDOM / 4);
        drain();
        write_cfg(gbs_pkg::CFG_DISTANCE, $urandom());
        write_cfg(gbs_pkg::CFG_GAIN, 32'($urandom_range(1 << 20)));
        sender_idle = 55;
        random_phase(N_RANDOM / 4);
        drain();
        write_cfg(gbs_pkg::CFG_DISTANCE, 32'($urandom_range(1 << 24, 2)));
        write_cfg(gbs_pkg::CFG_GAIN, $urandom());
        sender_idle = 0;
        random_phase(N_RANDOM / 4);
        drain();
        write_cfg(gbs_pkg::CFG_DISTANCE, 32'h7FFF_FFFF);
        write_cfg(gbs_pkg::CFG_GAIN, 32'($urandom_range(1 << 18)));
        random_phase(N_RANDOM - 3 * (N_RANDOM / 4));
        drain();

        if (sb.errors == 0 && sb.idx_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
